// File: sv/bvm_pkg.sv
// Types, constants and register codes shared by the battery voltage monitor.
// No dependencies; every other file of the block imports this package.
package bvm_pkg;

  // ADC and scaling
  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned FULL_SCALE  = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned SCALE_TOP   = 330;
  localparam int unsigned SCALED_W    = 9;   // holds 0..SCALE_TOP

  // Accumulator and reading
  localparam int unsigned SUM_W       = 16;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned READ_W      = 13;
  localparam int unsigned OFFS_W      = 8;
  localparam int unsigned READING_MAX = (1 << READ_W) - 1;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned SEG_W       = 7;

  // Divide by three on a SUM_W value: (x * 43691) >> 17 is exact below 2^17
  localparam int unsigned DIV3_SHIFT  = 17;
  localparam logic [16:0] DIV3_MUL    = 17'd43691;

  // Configuration port
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 13;

  localparam logic [CNT_W-1:0]  SAMPLES_RST  = CNT_W'(36);
  localparam logic [OFFS_W-1:0] OFFSET_RST   = OFFS_W'(20);
  localparam logic [READ_W-1:0] CUT_LO_RST   = READ_W'(1120);
  localparam logic [READ_W-1:0] CUT_HI_RST   = READ_W'(1500);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLES         = 2'd0,
    REG_OFFSET          = 2'd1,
    REG_CUT_NO_SUPPLY   = 2'd2,
    REG_CUT_WITH_SUPPLY = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_BUTTON = 1'b1
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   supply_sense;
    logic                   button_level;
  } in_item_t;

  typedef struct packed {
    logic                   switch_on;
    logic                   reading_done;
    logic [READ_W-1:0]      reading;
    logic [DIGIT_W-1:0]     digit_high;
    logic [DIGIT_W-1:0]     digit_middle;
    logic [DIGIT_W-1:0]     digit_low;
    logic [SEG_W-1:0]       segments_high;
    logic [SEG_W-1:0]       segments_middle;
    logic [SEG_W-1:0]       segments_low;
  } out_item_t;

  // Classified item handed from the front queue to the back end
  typedef struct packed {
    op_e                 op;
    logic [SCALED_W-1:0] scaled;
    logic                supply;
    logic                button;
  } work_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  samples;
    logic [OFFS_W-1:0] offset;
    logic [READ_W-1:0] cut_no_supply;
    logic [READ_W-1:0] cut_with_supply;
  } cfg_t;

  // Result of the state update, before display decoding
  typedef struct packed {
    logic              switch_on;
    logic              reading_done;
    logic [READ_W-1:0] reading;
  } stat_t;

endpackage

// File: sv/bvm_front.sv
// Front end: accepts input beats, scales ADC samples by 330/full-scale and
// queues classified items. Depends on bvm_pkg.
module bvm_front import bvm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       q_valid_o,
  input  logic       q_ready_i,
  output work_item_t q_data_o
);

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);

  // x / (2^n - 1): split x into high and low parts and fold twice
  logic [SAMPLE_BITS+SCALED_W-1:0] prod;
  logic [SCALED_W-1:0]             q0;
  logic [SAMPLE_BITS+1:0]          t1;
  logic [1:0]                      q1;
  logic [SAMPLE_BITS:0]            t2;
  logic                            q2;
  logic [SCALED_W-1:0]             scaled;
  work_item_t                      item;

  always_comb begin
    prod = in_data_i.sample * SCALED_W'(SCALE_TOP);
    q0   = SCALED_W'(prod >> SAMPLE_BITS);
    t1   = (SAMPLE_BITS+2)'(q0) + (SAMPLE_BITS+2)'(prod[SAMPLE_BITS-1:0]);
    q1   = t1[SAMPLE_BITS+1:SAMPLE_BITS];
    t2   = (SAMPLE_BITS+1)'(t1[SAMPLE_BITS-1:0]) + (SAMPLE_BITS+1)'(q1);
    q2   = (t2 >= (SAMPLE_BITS+1)'(FULL_SCALE));
    scaled = q0 + SCALED_W'(q1) + SCALED_W'(q2);

    item.op     = in_data_i.op;
    item.scaled = scaled;
    item.supply = in_data_i.supply_sense;
    item.button = in_data_i.button_level;
  end

  // Two-entry queue
  work_item_t       mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   cnt_q, cnt_d;
  logic             push, pop;

  assign in_ready_o = (cnt_q != (PTR_W+1)'(QDEPTH));
  assign q_valid_o  = (cnt_q != '0);
  assign q_data_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

// File: sv/bvm_back.sv
// Back end: accumulates scaled samples, closes readings, applies the cutoff
// and button toggling. Depends on bvm_pkg.
module bvm_back import bvm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       item_valid_i,
  output logic       item_ready_o,
  input  work_item_t item_i,
  output logic       stat_valid_o,
  input  logic       stat_ready_i,
  output stat_t      stat_o
);

  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [READ_W-1:0] reading_q, reading_d;
  logic              switch_q, switch_d;
  logic              valid_q;
  stat_t             stat_q, stat_d;

  logic                          take;
  logic [SUM_W-1:0]              sum_new;
  logic [CNT_W-1:0]              cnt_new;
  logic                          close;
  logic [SUM_W+16:0]             prod3;
  logic [SUM_W-2:0]              third;
  logic [SUM_W-1:0]              val;
  logic [READ_W-1:0]             val_sat;
  logic                          cut;

  assign item_ready_o = !valid_q || stat_ready_i;
  assign take         = item_valid_i && item_ready_o;
  assign stat_valid_o = valid_q;
  assign stat_o       = stat_q;

  always_comb begin
    sum_new = sum_q + SUM_W'(item_i.scaled);
    cnt_new = cnt_q + CNT_W'(1);
    close   = (item_i.op == OP_SAMPLE) && (cnt_new >= cfg_i.samples);
    prod3   = sum_new * DIV3_MUL;
    third   = prod3[DIV3_SHIFT +: SUM_W-1];
    val     = SUM_W'(third) + SUM_W'(cfg_i.offset);
    val_sat = (val > SUM_W'(READING_MAX)) ? READ_W'(READING_MAX) : val[READ_W-1:0];
    cut     = item_i.supply ? (val_sat <= cfg_i.cut_with_supply)
                            : (val_sat <= cfg_i.cut_no_supply);

    sum_d     = sum_q;
    cnt_d     = cnt_q;
    reading_d = reading_q;
    switch_d  = switch_q;
    if (item_i.op == OP_SAMPLE) begin
      if (close) begin
        sum_d     = '0;
        cnt_d     = '0;
        reading_d = val_sat;
        if (cut) begin
          switch_d = 1'b0;
        end
      end else begin
        sum_d = sum_new;
        cnt_d = cnt_new;
      end
    end else if (item_i.button) begin
      switch_d = !switch_q;
    end

    stat_d.switch_on    = switch_d;
    stat_d.reading_done = close;
    stat_d.reading      = reading_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      cnt_q     <= '0;
      reading_q <= '0;
      switch_q  <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      if (take) begin
        sum_q     <= sum_d;
        cnt_q     <= cnt_d;
        reading_q <= reading_d;
        switch_q  <= switch_d;
      end
      if (item_ready_o) begin
        valid_q <= take;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      stat_q <= stat_d;
    end
  end

endmodule

// File: sv/bvm_disp.sv
// Display stage: splits the reading into decimal digits, looks up the
// active-low segment patterns and holds the result beat. Depends on bvm_pkg.
module bvm_disp import bvm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      stat_valid_i,
  output logic      stat_ready_o,
  input  stat_t     stat_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned MAX_THOUSANDS = READING_MAX / 1000;
  localparam logic [SEG_W-1:0] SEG_BLANK = 7'h7F;
  localparam logic [SEG_W-1:0] SEG_CODE [10] = '{
    7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h10
  };

  function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    s = SEG_BLANK;
    if (d < DIGIT_W'(10)) begin
      s = SEG_CODE[d];
    end
    return s;
  endfunction

  logic               valid_q;
  out_item_t          out_q, out_d;
  logic               take;
  logic [DIGIT_W-1:0] dh, dm, dl;
  logic [READ_W-1:0]  sub_h;
  logic [9:0]         rem_h, sub_m;
  logic [6:0]         rem_m;

  assign stat_ready_o = !valid_q || out_ready_i;
  assign take         = stat_valid_i && stat_ready_o;
  assign out_valid_o  = valid_q;
  assign out_data_o   = out_q;

  // Compare against every multiple, then subtract the largest one reached
  always_comb begin
    dh    = '0;
    sub_h = '0;
    for (int k = 1; k <= MAX_THOUSANDS; k++) begin
      if (stat_i.reading >= READ_W'(k * 1000)) begin
        dh    = DIGIT_W'(k);
        sub_h = READ_W'(k * 1000);
      end
    end
    rem_h = 10'(stat_i.reading - sub_h);

    dm    = '0;
    sub_m = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem_h >= 10'(k * 100)) begin
        dm    = DIGIT_W'(k);
        sub_m = 10'(k * 100);
      end
    end
    rem_m = 7'(rem_h - sub_m);

    dl    = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem_m >= 7'(k * 10)) begin
        dl    = DIGIT_W'(k);
      end
    end

    out_d.switch_on       = stat_i.switch_on;
    out_d.reading_done    = stat_i.reading_done;
    out_d.reading         = stat_i.reading;
    out_d.digit_high      = dh;
    out_d.digit_middle    = dm;
    out_d.digit_low       = dl;
    out_d.segments_high   = seg_of(dh);
    out_d.segments_middle = seg_of(dm);
    out_d.segments_low    = seg_of(dl);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (stat_ready_o) begin
      valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

endmodule

// File: sv/battery_voltage_monitor_cutoff.sv
// Battery voltage monitor with low-voltage cutoff and three-digit display.
// A result beat passes the queue write, the back-end state update and the display
// decode, each registered. Throughput: one item per cycle while the result channel
// is not stalled, carried by the accumulator update in the back end.
// Reset: configuration returns to 36 samples, offset 20, cutoffs 1120/1500;
// sum, count, reading and switch clear; queue and output stages empty.
module battery_voltage_monitor_cutoff import bvm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // Configuration registers; the user must write them only while the block is idle (not enforced)
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.samples         <= SAMPLES_RST;
      cfg_q.offset          <= OFFSET_RST;
      cfg_q.cut_no_supply   <= CUT_LO_RST;
      cfg_q.cut_with_supply <= CUT_HI_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SAMPLES:         cfg_q.samples         <= cfg_wdata_i[CNT_W-1:0];
        REG_OFFSET:          cfg_q.offset          <= cfg_wdata_i[OFFS_W-1:0];
        REG_CUT_NO_SUPPLY:   cfg_q.cut_no_supply   <= cfg_wdata_i[READ_W-1:0];
        REG_CUT_WITH_SUPPLY: cfg_q.cut_with_supply <= cfg_wdata_i[READ_W-1:0];
      endcase
    end
  end

  // Front: scale each sample and park the classified item in a short queue
  logic       q_valid, q_ready;
  work_item_t q_data;

  bvm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_data_o   (q_data)
  );

  // Back: advance the accumulator, close readings, drive the switch
  logic  stat_valid, stat_ready;
  stat_t stat;

  bvm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_data),
    .stat_valid_o (stat_valid),
    .stat_ready_i (stat_ready),
    .stat_o       (stat)
  );

  // Display: decode digits and segments, hold the result beat
  bvm_disp u_disp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stat_valid_i (stat_valid),
    .stat_ready_o (stat_ready),
    .stat_i       (stat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // Digits must reassemble the reading down to its tens
  a_digits_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (int'(out_data_o.digit_high) * 1000 + int'(out_data_o.digit_middle) * 100 +
       int'(out_data_o.digit_low) * 10 <= int'(out_data_o.reading)) &&
      (int'(out_data_o.reading) - int'(out_data_o.digit_high) * 1000 -
       int'(out_data_o.digit_middle) * 100 - int'(out_data_o.digit_low) * 10 < 10))
    else $error("display digits do not match reading");

  // Every digit is decimal, so no pattern is ever blank
  a_no_blank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.segments_high != 7'h7F) &&
                    (out_data_o.segments_middle != 7'h7F) &&
                    (out_data_o.segments_low != 7'h7F))
    else $error("blank segment pattern on a decimal digit");

  // A back-end beat waiting on a stalled display stage must not be replaced
  a_stat_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat_valid && !stat_ready) |=> stat_valid && $stable(stat))
    else $error("back-end result lost under stall");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for battery_voltage_monitor_cutoff: directed and random beats
// are checked against a cycle-free model of the sample accumulator, cutoff and display.
// Depends on bvm_pkg (sv/bvm_pkg.sv) and the block's RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bvm_pkg::*;

  localparam int unsigned CLK_HALF       = 5;
  localparam int unsigned RESET_CYCLES   = 8;
  // Extra margin after the last owed status beat has been taken.
  localparam int unsigned DRAIN_CYCLES   = 4;
  // Far above both the longest stall and a full register update.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS   = 450;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Gaps and stalls are on while this is set; clear it for back-to-back stretches.
  bit          idle_on        = 1'b1;
  int unsigned stall_cycles   = 0;
  int unsigned idle_count     = 0;
  int unsigned mismatch_count = 0;
  int unsigned random_sent    = 0;

  // Monitor model: register copies, accumulator, latest reading and switch.
  logic [CNT_W-1:0]  cfg_samples         = SAMPLES_RST;
  logic [OFFS_W-1:0] cfg_offset          = OFFSET_RST;
  logic [READ_W-1:0] cfg_cut_no_supply   = CUT_LO_RST;
  logic [READ_W-1:0] cfg_cut_with_supply = CUT_HI_RST;
  logic [SUM_W-1:0]  acc_sum             = '0;
  logic [CNT_W-1:0]  acc_count           = '0;
  logic [READ_W-1:0] last_reading        = '0;
  logic              switch_state        = 1'b0;

  // Status beats the block owes us, oldest first.
  out_item_t expected_status[$];

  battery_voltage_monitor_cutoff dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Active-low segments a..g, bit 0 = a; anything past nine blanks the digit.
  function automatic logic [SEG_W-1:0] segment_pattern(logic [DIGIT_W-1:0] digit);
    case (digit)
      4'd0: return 7'h40;
      4'd1: return 7'h79;
      4'd2: return 7'h24;
      4'd3: return 7'h30;
      4'd4: return 7'h19;
      4'd5: return 7'h12;
      4'd6: return 7'h02;
      4'd7: return 7'h78;
      4'd8: return 7'h00;
      4'd9: return 7'h10;
      default: return 7'h7F;
    endcase
  endfunction

  // Advance the monitor model by one accepted beat and return the status it owes.
  function automatic out_item_t advance_monitor(in_item_t item);
    int unsigned scaled;
    int unsigned total;
    out_item_t   status;
    status = '0;
    if (item.op == OP_SAMPLE) begin
      scaled    = (32'(item.sample) * SCALE_TOP) / FULL_SCALE;
      acc_count = acc_count + 1'b1;
      acc_sum   = acc_sum + scaled[SUM_W-1:0];
      // Compare with >= so a count already past a lowered setting closes at once.
      if (acc_count >= cfg_samples) begin
        total = acc_sum / 3 + cfg_offset;
        if (total > READING_MAX) total = READING_MAX;
        last_reading = total[READ_W-1:0];
        if ((!item.supply_sense && last_reading <= cfg_cut_no_supply) ||
            (item.supply_sense && last_reading <= cfg_cut_with_supply)) begin
          switch_state = 1'b0;
        end
        acc_count = '0;
        acc_sum   = '0;
        status.reading_done = 1'b1;
      end
    end else if (item.button_level) begin
      switch_state = ~switch_state;
    end
    status.switch_on       = switch_state;
    status.reading         = last_reading;
    status.digit_high      = DIGIT_W'(last_reading / 1000);
    status.digit_middle    = DIGIT_W'((last_reading % 1000) / 100);
    status.digit_low       = DIGIT_W'((last_reading % 100) / 10);
    status.segments_high   = segment_pattern(status.digit_high);
    status.segments_middle = segment_pattern(status.digit_middle);
    status.segments_low    = segment_pattern(status.digit_low);
    return status;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned gap_length();
    int unsigned roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic in_item_t sample_item(int unsigned raw, bit supply);
    in_item_t item;
    item.op           = OP_SAMPLE;
    item.sample       = raw[SAMPLE_BITS-1:0];
    item.supply_sense = supply;
    item.button_level = 1'($urandom_range(0, 1));
    return item;
  endfunction

  function automatic in_item_t button_item(bit level);
    in_item_t item;
    item.op           = OP_BUTTON;
    item.sample       = SAMPLE_BITS'($urandom_range(0, FULL_SCALE));
    item.supply_sense = 1'($urandom_range(0, 1));
    item.button_level = level;
    return item;
  endfunction

  // Mostly samples, pinned to the rails a fifth of the time; the rest button events.
  function automatic in_item_t random_item();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if ($urandom_range(0, 4) == 0) return button_item(1'($urandom_range(0, 1)));
    if (roll == 0) return sample_item(0, 1'($urandom_range(0, 1)));
    if (roll == 1) return sample_item(FULL_SCALE, 1'($urandom_range(0, 1)));
    return sample_item($urandom_range(0, FULL_SCALE), 1'($urandom_range(0, 1)));
  endfunction

  // Offer one beat after a random gap, hold it until taken, then book its status.
  // Valid stays high on return so back-to-back beats need no second assignment.
  task automatic send_item(in_item_t item);
    int unsigned gap;
    gap = gap_length();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    expected_status.push_back(advance_monitor(item));
  endtask

  // Drop valid and let every owed status drain before touching registers.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; the caller lowers the write enable after the last one.
  task automatic put_reg(cfg_reg_e idx, int unsigned value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    case (idx)
      REG_SAMPLES:         cfg_samples         = value[CNT_W-1:0];
      REG_OFFSET:          cfg_offset          = value[OFFS_W-1:0];
      REG_CUT_NO_SUPPLY:   cfg_cut_no_supply   = value[READ_W-1:0];
      REG_CUT_WITH_SUPPLY: cfg_cut_with_supply = value[READ_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned samples, int unsigned offset,
                            int unsigned cut_no, int unsigned cut_with);
    wait_idle();
    put_reg(REG_SAMPLES, samples);
    put_reg(REG_OFFSET, offset);
    put_reg(REG_CUT_NO_SUPPLY, cut_no);
    put_reg(REG_CUT_WITH_SUPPLY, cut_with);
    cfg_we <= 1'b0;
  endtask

  // Level low leaves the switch alone; level high flips it each time.
  task automatic test_button_toggle();
    send_item(button_item(1'b0));
    send_item(button_item(1'b1));
    send_item(button_item(1'b1));
    send_item(button_item(1'b1));
  endtask

  // Run the reset register values untouched: 36 samples per reading, offset 20.
  task automatic test_reset_config();
    repeat (2 * 36 + 10) begin
      send_item(random_item());
      random_sent++;
    end
  endtask

  // One sample per reading, then zero samples per reading (every sample closes too).
  task automatic test_single_sample_readings();
    set_config(1, 0, 0, READING_MAX);
    send_item(sample_item(0, 1'b0));           // zero reading at a zero cutoff: clear
    send_item(button_item(1'b1));
    send_item(sample_item(FULL_SCALE, 1'b0));  // above the cutoff: hold on
    send_item(sample_item(FULL_SCALE, 1'b1));  // top cutoff with supply: clear
    set_config(0, 255, 0, READING_MAX);
    send_item(sample_item(FULL_SCALE, 1'b0));
    send_item(sample_item(512, 1'b1));
  endtask

  // Readings exactly at and one above each cutoff (930 -> 100, 940 -> 101).
  task automatic test_cutoff_boundary();
    set_config(1, 0, 100, 100);
    send_item(button_item(1'b1));
    send_item(sample_item(930, 1'b1));
    send_item(button_item(1'b1));
    send_item(sample_item(940, 1'b1));
    send_item(sample_item(940, 1'b0));
    send_item(sample_item(930, 1'b0));
  endtask

  // Lower samples per reading below the running count; the next sample closes.
  task automatic test_count_lowered();
    set_config(10, OFFSET_RST, CUT_LO_RST, CUT_HI_RST);
    repeat (5) send_item(sample_item($urandom_range(0, FULL_SCALE), 1'($urandom_range(0, 1))));
    set_config(3, OFFSET_RST, CUT_LO_RST, CUT_HI_RST);
    send_item(sample_item($urandom_range(0, FULL_SCALE), 1'($urandom_range(0, 1))));
  endtask

  // Random phases, each under fresh settings; the first uses the widest reading.
  // Cutoffs mostly land inside the range the phase's readings can reach.
  task automatic test_random_phases();
    int unsigned phase;
    int unsigned roll;
    int unsigned samples;
    int unsigned offset;
    int unsigned top;
    int unsigned cut_no;
    int unsigned cut_with;
    int unsigned count;
    phase = 1;
    while (random_sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 9);
      if (phase == 1) samples = 63;
      else if (roll < 6) samples = $urandom_range(1, 6);
      else if (roll < 8) samples = $urandom_range(7, 20);
      else if (roll == 8) samples = 0;
      else samples = 63;
      roll = $urandom_range(0, 4);
      offset = (roll == 0) ? 0 : (roll == 1) ? 255 : $urandom_range(0, 255);
      top = offset + 110 * ((samples == 0) ? 1 : samples);
      if (top > READING_MAX) top = READING_MAX;
      roll = $urandom_range(0, 9);
      cut_no = (roll == 0) ? 0 : (roll == 1) ? READING_MAX : $urandom_range(offset, top);
      roll = $urandom_range(0, 9);
      cut_with = (roll == 0) ? 0 : (roll == 1) ? READING_MAX : $urandom_range(offset, top);
      set_config(samples, offset, cut_no, cut_with);
      // Every third phase runs flat out on both sides.
      idle_on = (phase % 3) != 0;
      count = (samples > 20) ? 2 * samples + 10 : 40;
      // Stop at the item budget.
      if (count > RANDOM_ITEMS - random_sent) count = RANDOM_ITEMS - random_sent;
      repeat (count) begin
        send_item(random_item());
        random_sent++;
      end
      phase++;
    end
    idle_on = 1'b1;
  endtask

  // Result side: hold ready high for a cycle, then maybe stall for a while.
  always @(posedge clk) begin
    if (stall_cycles == 0) begin
      out_ready <= 1'b1;
      stall_cycles = (idle_on && $urandom_range(0, 2) == 0) ? gap_length() : 0;
    end else begin
      out_ready <= 1'b0;
      stall_cycles--;
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each status beat the block hands over with the oldest booked one.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        $error("status beat with nothing expected: %p", out_data);
        mismatch_count++;
      end else begin
        want = expected_status.pop_front();
        check_field("switch_on", want.switch_on, out_data.switch_on);
        check_field("reading_done", want.reading_done, out_data.reading_done);
        check_field("reading", want.reading, out_data.reading);
        check_field("digit_high", want.digit_high, out_data.digit_high);
        check_field("digit_middle", want.digit_middle, out_data.digit_middle);
        check_field("digit_low", want.digit_low, out_data.digit_low);
        check_field("segments_high", want.segments_high, out_data.segments_high);
        check_field("segments_middle", want.segments_middle, out_data.segments_middle);
        check_field("segments_low", want.segments_low, out_data.segments_low);
      end
    end
  end

  // Stop a hung run: too many cycles in a row with no beat on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_count = 0;
    else idle_count++;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_button_toggle();
    test_reset_config();
    test_single_sample_readings();
    test_cutoff_boundary();
    test_count_lowered();
    test_random_phases();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
sv/bvm_pkg.sv
sv/bvm_front.sv
sv/bvm_back.sv
sv/bvm_disp.sv
sv/battery_voltage_monitor_cutoff.sv
tb/testbench.sv
